/* hdl/kvd_pkg.sv */
// ----------------------------------------------------------------------------
// kvd_pkg: shared types and constants of the key/value record deframer
// Character codes, result kinds, error codes, queue sizing and the
// transaction structs that pass between the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package kvd_pkg;

  // width of the parsed length counters
  localparam int LEN_WIDTH = 16;
  // accumulator width: count * 10 + 9 fits in LEN_WIDTH + 4 bits
  localparam int VAL_WIDTH = LEN_WIDTH + 4;
  localparam logic [VAL_WIDTH-1:0] LEN_MAX = VAL_WIDTH'((64'd1 << LEN_WIDTH) - 64'd1);
  localparam logic [VAL_WIDTH-1:0] RADIX   = VAL_WIDTH'(10);

  // record syntax characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result kinds
  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_KEY  = 3'd1;
  localparam logic [2:0] K_VAL  = 3'd2;
  localparam logic [2:0] K_FIN  = 3'd3;
  localparam logic [2:0] K_ERR  = 3'd4;

  // error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_KEY_LEN  = 3'd1;
  localparam logic [2:0] E_VAL_LEN  = 3'd2;
  localparam logic [2:0] E_SEP      = 3'd3;
  localparam logic [2:0] E_NEWLINE  = 3'd4;
  localparam logic [2:0] E_OP       = 3'd5;
  localparam logic [2:0] E_TRUNC    = 3'd6;
  localparam logic [2:0] E_TOO_LONG = 3'd7;

  // configuration register indexes
  localparam logic REG_MAX_KEY = 1'b0;
  localparam logic REG_MAX_VAL = 1'b1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QLW    = 3;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       digit;
    logic [3:0] digit_val;
    logic       plus;
    logic       comma;
    logic       colon;
    logic       dash;
    logic       gt;
    logic       nl;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        commit;
    logic [15:0] klen;
    logic [15:0] vlen;
    logic [2:0]  ecode;
  } result_t;

  // queue status
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QLW-1:0] level;
  } qstat_t;

endpackage

`default_nettype wire

/* hdl/kvd_front.sv */
// ----------------------------------------------------------------------------
// kvd_front: input acceptance and byte classification
// Decodes each incoming byte into syntax flags and a digit value and pushes
// the classified transaction into the queue while it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module kvd_front (
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,
  input  wire logic          in_tuser,
  input  wire kvd_pkg::qstat_t stat,
  output logic               push,
  output kvd_pkg::item_t     item
);

  logic [7:0] diff;

  assign in_tready = !stat.full;
  assign push      = in_tvalid && in_tready;
  assign diff      = in_tdata - kvd_pkg::CH_ZERO;

  always_comb begin
    item.data      = in_tdata;
    item.eoi       = in_tuser;
    item.digit     = (in_tdata >= kvd_pkg::CH_ZERO) && (in_tdata <= kvd_pkg::CH_NINE);
    item.digit_val = diff[3:0];
    item.plus      = (in_tdata == kvd_pkg::CH_PLUS);
    item.comma     = (in_tdata == kvd_pkg::CH_COMMA);
    item.colon     = (in_tdata == kvd_pkg::CH_COLON);
    item.dash      = (in_tdata == kvd_pkg::CH_DASH);
    item.gt        = (in_tdata == kvd_pkg::CH_GT);
    item.nl        = (in_tdata == kvd_pkg::CH_NL);
  end

endmodule

`default_nettype wire

/* hdl/kvd_fifo.sv */
// ----------------------------------------------------------------------------
// kvd_fifo: short queue of classified bytes
// Small register queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module kvd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire kvd_pkg::item_t item_in,
  input  wire logic           pop,
  output kvd_pkg::item_t      head,
  output kvd_pkg::qstat_t     stat
);

  kvd_pkg::item_t mem_r [kvd_pkg::QDEPTH];

  logic [kvd_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [kvd_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [kvd_pkg::QLW-1:0] level_r, level_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.full  = (level_r == kvd_pkg::QLW'(kvd_pkg::QDEPTH));
  assign stat.empty = (level_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/kvd_back.sv */
// ----------------------------------------------------------------------------
// kvd_back: record parser and result register
// Runs the record state machine on the queue head, one byte per cycle while
// bytes wait and results are taken; each result stays registered until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kvd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire kvd_pkg::item_t  head,
  input  wire kvd_pkg::qstat_t stat,
  output logic                 pop,
  input  wire logic [15:0]     max_key_len,
  input  wire logic [15:0]     max_value_len,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output kvd_pkg::result_t     result
);

  localparam logic [3:0] P_OP   = 4'd0;
  localparam logic [3:0] P_KLEN = 4'd1;
  localparam logic [3:0] P_VLEN = 4'd2;
  localparam logic [3:0] P_KEY  = 4'd3;
  localparam logic [3:0] P_SEP1 = 4'd4;
  localparam logic [3:0] P_SEP2 = 4'd5;
  localparam logic [3:0] P_VAL  = 4'd6;
  localparam logic [3:0] P_NL   = 4'd7;
  localparam logic [3:0] P_DONE = 4'd8;
  localparam logic [3:0] P_ERR  = 4'd9;

  logic [3:0]                   phase_r, phase_nxt;
  logic [2:0]                   err_r, err_nxt;
  logic                         ins_r, ins_nxt;
  logic [kvd_pkg::LEN_WIDTH-1:0] kcnt_r, kcnt_nxt;
  logic [kvd_pkg::LEN_WIDTH-1:0] vcnt_r, vcnt_nxt;
  logic [kvd_pkg::LEN_WIDTH-1:0] left_r, left_nxt;
  logic [kvd_pkg::LEN_WIDTH-1:0] left_dec;
  logic                         out_valid_r;
  kvd_pkg::result_t             res_r, res_nxt;

  logic [kvd_pkg::VAL_WIDTH-1:0] kacc, vacc;
  logic                          k_big, v_big;

  assign pop       = !stat.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = res_r;
  assign left_dec  = left_r - 1'b1;

  // decimal accumulate and range check
  always_comb begin
    kacc  = kvd_pkg::VAL_WIDTH'(kcnt_r) * kvd_pkg::RADIX
          + kvd_pkg::VAL_WIDTH'(head.digit_val);
    vacc  = kvd_pkg::VAL_WIDTH'(vcnt_r) * kvd_pkg::RADIX
          + kvd_pkg::VAL_WIDTH'(head.digit_val);
    k_big = (kacc > kvd_pkg::VAL_WIDTH'(max_key_len)) || (kacc > kvd_pkg::LEN_MAX);
    v_big = (vacc > kvd_pkg::VAL_WIDTH'(max_value_len)) || (vacc > kvd_pkg::LEN_MAX);
  end

  always_comb begin
    logic       fail;
    logic [2:0] code;
    logic       fin;
    fail      = 1'b0;
    code      = kvd_pkg::E_NONE;
    fin       = 1'b0;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    ins_nxt   = ins_r;
    kcnt_nxt  = kcnt_r;
    vcnt_nxt  = vcnt_r;
    left_nxt  = left_r;
    res_nxt   = '0;
    res_nxt.kind = kvd_pkg::K_NONE;

    case (phase_r)
      P_ERR: begin
        res_nxt.kind  = kvd_pkg::K_ERR;
        res_nxt.ecode = err_r;
      end
      P_DONE: begin
        res_nxt.kind = kvd_pkg::K_FIN;
      end
      default: begin
        if (head.eoi) begin
          if (phase_r == P_OP) begin
            phase_nxt    = P_DONE;
            res_nxt.kind = kvd_pkg::K_FIN;
          end else begin
            fail = 1'b1;
            code = kvd_pkg::E_TRUNC;
          end
        end else begin
          case (phase_r)
            P_OP: begin
              ins_nxt   = head.plus;
              kcnt_nxt  = '0;
              vcnt_nxt  = '0;
              left_nxt  = '0;
              phase_nxt = P_KLEN;
            end
            P_KLEN: begin
              if (head.digit) begin
                if (k_big) begin
                  fail = 1'b1;
                  code = kvd_pkg::E_TOO_LONG;
                end else begin
                  kcnt_nxt = kacc[kvd_pkg::LEN_WIDTH-1:0];
                end
              end else if (head.comma) begin
                phase_nxt = P_VLEN;
              end else begin
                fail = 1'b1;
                code = kvd_pkg::E_KEY_LEN;
              end
            end
            P_VLEN: begin
              if (head.digit) begin
                if (v_big) begin
                  fail = 1'b1;
                  code = kvd_pkg::E_TOO_LONG;
                end else begin
                  vcnt_nxt = vacc[kvd_pkg::LEN_WIDTH-1:0];
                end
              end else if (head.colon) begin
                left_nxt  = kcnt_r;
                phase_nxt = (kcnt_r == '0) ? P_SEP1 : P_KEY;
              end else begin
                fail = 1'b1;
                code = kvd_pkg::E_VAL_LEN;
              end
            end
            P_KEY: begin
              left_nxt     = left_dec;
              res_nxt.kind = kvd_pkg::K_KEY;
              res_nxt.data = head.data;
              if (left_dec == '0) begin
                phase_nxt = P_SEP1;
              end
            end
            P_SEP1: begin
              if (!head.dash) begin
                fail = 1'b1;
                code = kvd_pkg::E_SEP;
              end else begin
                phase_nxt = P_SEP2;
              end
            end
            P_SEP2: begin
              if (!head.gt) begin
                fail = 1'b1;
                code = kvd_pkg::E_SEP;
              end else if (vcnt_r == '0) begin
                fin = 1'b1;
              end else begin
                left_nxt  = vcnt_r;
                phase_nxt = P_VAL;
              end
            end
            P_VAL: begin
              left_nxt     = left_dec;
              res_nxt.kind = kvd_pkg::K_VAL;
              res_nxt.data = head.data;
              if (left_dec == '0) begin
                fin = 1'b1;
              end
            end
            P_NL: begin
              if (!head.nl) begin
                fail = 1'b1;
                code = kvd_pkg::E_NEWLINE;
              end else begin
                phase_nxt = P_OP;
              end
            end
            default: begin
              fail = 1'b1;
              code = kvd_pkg::E_OP;
            end
          endcase
        end
      end
    endcase

    // record end: commit on insert, otherwise operation error
    if (fin) begin
      if (!ins_r) begin
        fail = 1'b1;
        code = kvd_pkg::E_OP;
      end else begin
        phase_nxt      = P_NL;
        res_nxt.commit = 1'b1;
        res_nxt.klen   = 16'(kcnt_r);
        res_nxt.vlen   = 16'(vcnt_r);
      end
    end

    if (fail) begin
      phase_nxt     = P_ERR;
      err_nxt       = code;
      res_nxt       = '0;
      res_nxt.kind  = kvd_pkg::K_ERR;
      res_nxt.ecode = code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_OP;
      err_r       <= kvd_pkg::E_NONE;
      ins_r       <= 1'b0;
      kcnt_r      <= '0;
      vcnt_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
        ins_r   <= ins_nxt;
        kcnt_r  <= kcnt_nxt;
        vcnt_r  <= vcnt_nxt;
        left_r  <= left_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/kv_record_deframer.sv */
// ----------------------------------------------------------------------------
// kv_record_deframer: streaming parser for "+klen,vlen:key->value\n" records
// Splits a byte stream into tagged key and value bytes with a commit mark
// per record, a clean finish on end of input and a latched error code.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the queue has room, and returns
// exactly one result transaction for every input transaction, in order.
// Sustained rate is one byte per cycle while out_tready stays high. A byte
// is first written into the queue, and the back then loads its result from
// the queue head into the output register that drives out_tvalid. The front
// classifies each byte and writes it into a four-entry queue; the back runs
// the record state machine on the queue head and updates the length counters
// with one multiply-by-ten add and range compare per cycle.
// Backpressure on the result side fills the queue and then drops in_tready.
// A key or value byte comes out with kind 1 or 2; the last value byte of a
// record (or a kindless result at the '>' when the value is empty) carries
// out_tlast with both lengths. After end of input at a record start every
// result is a clean finish; after any fault every result is an error with
// the same code, until reset. The user must write the length limits over the
// register port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] end_of_input
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] out_byte, [23:8] key_length,
                                       // [39:24] value_length, [42:40] error_code
  output logic             out_tlast,  // commit
  output logic [2:0]       out_tuser,  // [2:0] out_kind
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // length limit registers
  logic [15:0] max_key_len_r;
  logic [15:0] max_value_len_r;
  logic        reg_wr;

  // front to queue
  logic             push;
  kvd_pkg::item_t   item;
  // queue to back
  kvd_pkg::item_t   head;
  kvd_pkg::qstat_t  stat;
  logic             pop;
  // back to output ports
  kvd_pkg::result_t result;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  // register read, decoded on the word index bit
  always_comb begin
    case (paddr[2])
      kvd_pkg::REG_MAX_KEY: prdata = {16'd0, max_key_len_r};
      kvd_pkg::REG_MAX_VAL: prdata = {16'd0, max_value_len_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_len_r   <= 16'hFFFF;
      max_value_len_r <= 16'hFFFF;
    end else if (reg_wr) begin
      if (paddr[2] == kvd_pkg::REG_MAX_KEY) begin
        max_key_len_r <= pwdata[15:0];
      end else begin
        max_value_len_r <= pwdata[15:0];
      end
    end
  end

  // classify and enqueue
  kvd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .push      (push),
    .item      (item)
  );

  // decouples the two sides
  kvd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .item_in (item),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  // record parser with output register
  kvd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .max_key_len   (max_key_len_r),
    .max_value_len (max_value_len_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .result        (result)
  );

  // result packing, highest field first
  assign out_tdata = {5'd0, result.ecode, result.vlen, result.klen, result.data};
  assign out_tlast = result.commit;
  assign out_tuser = result.kind;

  // commit only ever rides on a value byte or a kindless transaction
  a_commit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == kvd_pkg::K_VAL) || (out_tuser == kvd_pkg::K_NONE))
    else $error("commit on a transaction that is neither value byte nor none");

  // error code present exactly on error transactions
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == kvd_pkg::K_ERR) == (out_tdata[42:40] != kvd_pkg::E_NONE)))
    else $error("error code does not match result kind");

  // queue occupancy stays within its depth
  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= kvd_pkg::QLW'(kvd_pkg::QDEPTH))
    else $error("queue level beyond depth");

  // a popped entry always exists
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty && (stat.level != '0))
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

/* dv/kv_record_deframer_test.sv */
// ----------------------------------------------------------------------------
// kv_record_deframer_test: self-checking bench for the record deframer
// Feeds "+klen,vlen:key->value\n" byte streams through the input channel with
// random gaps, stalls the result channel at random, predicts every result
// transaction in a local parser and checks each field as results come out.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_record_deframer_test;
  import kvd_pkg::*;

  // one byte of the record stream as the driver sends it
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } stream_byte_t;

  // parser phases of the local predictor
  typedef enum logic [3:0] {
    P_OP, P_KLEN, P_VLEN, P_KEY, P_SEP1, P_SEP2, P_VAL, P_NL, P_DONE, P_ERR
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // bytes waiting to be sent and results waiting to come back
  stream_byte_t byte_backlog[$];
  result_t      predicted_results[$];
  int           queued_count = 0;
  int           accepted_count = 0;
  int           mismatches = 0;

  // predictor copy of the length limits and the parser state
  logic [15:0]  key_limit = 16'hFFFF;
  logic [15:0]  val_limit = 16'hFFFF;
  parse_phase_t ph = P_OP;
  logic [2:0]   err_latch = E_NONE;
  logic         insert_op = 1'b0;
  int           klen_acc = 0;
  int           vlen_acc = 0;
  int           remaining = 0;

  // idling state of both channels
  int in_gap = 0;
  int out_stall = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  kv_record_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tuser   (in_tuser),   // [0] end_of_input
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] byte, [23:8] klen, [39:24] vlen, [42:40] ecode
    .out_tlast  (out_tlast),  // commit
    .out_tuser  (out_tuser),  // [2:0] kind
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // generous bound on the whole run, the longest record included
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int cap(input int limit, input int n);
    return (limit < n) ? limit : n;
  endfunction

  // any fault latches its code; everything after answers with it
  function automatic result_t raise(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = K_ERR;
    r.ecode = code;
    ph = P_ERR;
    err_latch = code;
    return r;
  endfunction

  // record end: commit for an insert, otherwise the operation byte was bad
  function automatic result_t close_record(input logic [2:0] kind, input logic [7:0] data);
    result_t r;
    if (!insert_op) return raise(E_OP);
    r = '0;
    r.kind = kind;
    r.data = data;
    r.commit = 1'b1;
    r.klen = klen_acc[15:0];
    r.vlen = vlen_acc[15:0];
    ph = P_NL;
    return r;
  endfunction

  // advance the parser by one accepted transaction, store what must come out
  task automatic parse_step(input logic [7:0] c, input logic eoi);
    result_t r;
    logic    is_digit;
    int      acc;
    r = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    acc = 0;
    if (ph == P_ERR) begin
      r.kind = K_ERR;
      r.ecode = err_latch;
    end else if (ph == P_DONE) begin
      r.kind = K_FIN;
    end else if (eoi) begin
      // end of input is only clean at a record start
      if (ph == P_OP) begin
        ph = P_DONE;
        r.kind = K_FIN;
      end else begin
        r = raise(E_TRUNC);
      end
    end else begin
      case (ph)
        P_OP: begin
          insert_op = (c == CH_PLUS);
          klen_acc = 0;
          vlen_acc = 0;
          remaining = 0;
          ph = P_KLEN;
        end
        P_KLEN: begin
          if (is_digit) begin
            acc = klen_acc * 10 + (int'(c) - int'(CH_ZERO));
            if (acc > int'(key_limit)) r = raise(E_TOO_LONG);
            else klen_acc = acc;
          end else if (c == CH_COMMA) begin
            ph = P_VLEN;
          end else begin
            r = raise(E_KEY_LEN);
          end
        end
        P_VLEN: begin
          if (is_digit) begin
            acc = vlen_acc * 10 + (int'(c) - int'(CH_ZERO));
            if (acc > int'(val_limit)) r = raise(E_TOO_LONG);
            else vlen_acc = acc;
          end else if (c == CH_COLON) begin
            remaining = klen_acc;
            ph = (klen_acc == 0) ? P_SEP1 : P_KEY;
          end else begin
            r = raise(E_VAL_LEN);
          end
        end
        P_KEY: begin
          remaining = remaining - 1;
          if (remaining == 0) ph = P_SEP1;
          r.kind = K_KEY;
          r.data = c;
        end
        P_SEP1: begin
          if (c != CH_DASH) r = raise(E_SEP);
          else ph = P_SEP2;
        end
        P_SEP2: begin
          if (c != CH_GT) begin
            r = raise(E_SEP);
          end else if (vlen_acc == 0) begin
            // empty value: the commit rides on the separator
            r = close_record(K_NONE, 8'h00);
          end else begin
            remaining = vlen_acc;
            ph = P_VAL;
          end
        end
        P_VAL: begin
          remaining = remaining - 1;
          if (remaining == 0) begin
            r = close_record(K_VAL, c);
          end else begin
            r.kind = K_VAL;
            r.data = c;
          end
        end
        default: begin
          // the newline is checked after the commit
          if (c != CH_NL) r = raise(E_NEWLINE);
          else ph = P_OP;
        end
      endcase
    end
    predicted_results.push_back(r);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] data, input logic eoi = 1'b0);
    stream_byte_t b;
    b.data = data;
    b.eoi = eoi;
    byte_backlog.push_back(b);
    queued_count++;
  endtask

  // decimal length, sometimes with leading zeros, sometimes empty for zero
  task automatic push_len(input int n);
    string s;
    int    i;
    s = $sformatf("%0d", n);
    if (n == 0 && $urandom_range(0, 2) == 0) return;
    repeat ($urandom_range(0, 2)) push_byte(CH_ZERO);
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // operation byte, both lengths and the key bytes
  task automatic push_head(input logic [7:0] op, input int kl, input int vl);
    push_byte(op);
    push_len(kl);
    push_byte(CH_COMMA);
    push_len(vl);
    push_byte(CH_COLON);
    repeat (kl) push_byte(8'($urandom_range(0, 255)));
  endtask

  // separator and the value bytes
  task automatic push_tail(input int vl);
    push_byte(CH_DASH);
    push_byte(CH_GT);
    repeat (vl) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_record(input logic [7:0] op, input int kl, input int vl);
    push_head(op, kl, vl);
    push_tail(vl);
    push_byte(CH_NL);
  endtask

  // mostly short lengths, now and then up to the limit or 48
  function automatic int pick_len(input logic [15:0] limit);
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, cap(int'(limit), 6));
    return $urandom_range(0, cap(int'(limit), 48));
  endfunction

  task automatic push_records(input int count);
    int target;
    target = queued_count + count;
    while (queued_count < target) push_record(CH_PLUS, pick_len(key_limit), pick_len(val_limit));
  endtask

  // an error or a clean finish latches until reset, so one of them ends the
  // stream; which one is left to the seed
  task automatic push_ending();
    logic [7:0] b;
    int         kl;
    int         vl;
    int         cut;
    string      s;
    int         i;
    kl = pick_len(key_limit);
    vl = pick_len(val_limit);
    b = CH_NL;
    case ($urandom_range(0, 8))
      0: push_byte(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        push_byte(CH_PLUS);
        push_len(kl);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COMMA) b = 8'($urandom_range(0, 255));
        push_byte(b);
      end
      2: begin
        push_byte(CH_PLUS);
        push_len(kl);
        push_byte(CH_COMMA);
        push_len(vl);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON) b = 8'($urandom_range(0, 255));
        push_byte(b);
      end
      3: begin
        push_head(CH_PLUS, kl, vl);
        while (b == CH_DASH) b = 8'($urandom_range(0, 255));
        if (b == CH_NL) b = 8'($urandom_range(0, 255));
        if (b == CH_DASH) b = CH_GT;
        push_byte(b);
      end
      4: begin
        push_head(CH_PLUS, kl, vl);
        push_byte(CH_DASH);
        b = CH_GT;
        while (b == CH_GT) b = 8'($urandom_range(0, 255));
        push_byte(b);
      end
      5: begin
        push_head(CH_PLUS, kl, vl);
        push_tail(vl);
        while (b == CH_NL) b = 8'($urandom_range(0, 255));
        push_byte(b);
      end
      6: begin
        // non-insert operation: bytes flow until the commit point
        b = CH_PLUS;
        while (b == CH_PLUS) b = 8'($urandom_range(0, 255));
        push_record(b, kl, vl);
      end
      7: begin
        // backlog is empty here, so the cut stays inside this record
        push_record(CH_PLUS, kl, vl);
        cut = $urandom_range(1, byte_backlog.size() - 1);
        repeat (cut) begin
          void'(byte_backlog.pop_back());
          queued_count--;
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        push_byte(CH_PLUS);
        if ($urandom_range(0, 1) == 0) begin
          s = $sformatf("%0d", int'(key_limit) + 1);
        end else begin
          push_len(kl);
          push_byte(CH_COMMA);
          s = $sformatf("%0d", int'(val_limit) + 1);
        end
        for (i = 0; i < s.len(); i++) push_byte(s[i]);
      end
    endcase
    // latched behavior: random bytes and end marks must not change the answer
    repeat (20) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------- register port

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAX_KEY) key_limit = value;
    else val_limit = value;
  endtask

  task automatic check_reg(input logic idx);
    logic [31:0] want;
    want = {16'h0000, (idx == REG_MAX_KEY) ? key_limit : val_limit};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) flag_mismatch("register readback", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // idle until every queued byte went in and every result came out
  task automatic drain();
    while (accepted_count != queued_count || predicted_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- channels

  // mostly no gap, some short ones, a few long ones; calm stretches have none
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // input driver: predicts each transaction as it is accepted
  always @(posedge clk) begin : byte_driver
    stream_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_step(in_tdata, in_tuser);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          nxt = byte_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tuser <= nxt.eoi;
          in_gap = pick_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin : result_stall
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // result monitor: each transaction against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        flag_mismatch("result with nothing pending, kind", 0, out_tuser);
      end else begin
        want = predicted_results.pop_front();
        if (out_tuser !== want.kind) flag_mismatch("kind", want.kind, out_tuser);
        if (out_tdata[7:0] !== want.data) flag_mismatch("byte", want.data, out_tdata[7:0]);
        if (out_tlast !== want.commit) flag_mismatch("commit", want.commit, out_tlast);
        if (out_tdata[23:8] !== want.klen) flag_mismatch("key length", want.klen, out_tdata[23:8]);
        if (out_tdata[39:24] !== want.vlen)
          flag_mismatch("value length", want.vlen, out_tdata[39:24]);
        if (out_tdata[42:40] !== want.ecode)
          flag_mismatch("error code", want.ecode, out_tdata[42:40]);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int waited;
    waited = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // limits come out of reset at their maximum
    check_reg(REG_MAX_KEY);
    check_reg(REG_MAX_VAL);

    // empty digit strings, commit on the separator
    push_byte(CH_PLUS);
    push_byte(CH_COMMA);
    push_byte(CH_COLON);
    push_byte(CH_DASH);
    push_byte(CH_GT);
    push_byte(CH_NL);
    // one-byte key and value at the byte extremes
    push_byte(CH_PLUS);
    push_byte(CH_ZERO + 8'd1);
    push_byte(CH_COMMA);
    push_byte(CH_ZERO + 8'd1);
    push_byte(CH_COLON);
    push_byte(8'h00);
    push_byte(CH_DASH);
    push_byte(CH_GT);
    push_byte(8'hFF);
    push_byte(CH_NL);
    // leading zeros, syntax characters as payload
    push_byte(CH_PLUS);
    push_byte(CH_ZERO);
    push_byte(CH_ZERO);
    push_byte(CH_ZERO + 8'd2);
    push_byte(CH_COMMA);
    push_byte(CH_ZERO);
    push_byte(CH_ZERO + 8'd1);
    push_byte(CH_COLON);
    push_byte(CH_NL);
    push_byte(CH_GT);
    push_byte(CH_DASH);
    push_byte(CH_GT);
    push_byte(CH_COLON);
    push_byte(CH_NL);
    drain();

    // tightest limits: only zero lengths pass
    write_reg(REG_MAX_KEY, 16'h0000);
    write_reg(REG_MAX_VAL, 16'h0000);
    check_reg(REG_MAX_KEY);
    check_reg(REG_MAX_VAL);
    repeat (6) push_record(CH_PLUS, 0, 0);
    drain();

    // small random limits, with a full stop of the sender halfway
    write_reg(REG_MAX_KEY, 16'($urandom_range(1, 12)));
    write_reg(REG_MAX_VAL, 16'($urandom_range(1, 12)));
    push_records(150);
    drain();
    push_records(150);
    drain();

    // widest key limit, random value limit
    write_reg(REG_MAX_KEY, 16'hFFFF);
    write_reg(REG_MAX_VAL, 16'($urandom_range(0, 40)));
    check_reg(REG_MAX_VAL);
    push_records(280);
    drain();

    push_ending();

    // wait out the last results, then keep watching for anything stray
    while (accepted_count != queued_count) @(posedge clk);
    while (predicted_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (predicted_results.size() != 0)
      flag_mismatch("results never delivered", predicted_results.size(), 0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
